// ===== hw/rtl/dri_pkg.sv =====
// Package with constants, types and tables for the dead reckoning integrator.
package dri_pkg;
  localparam int AngleBits   = 16;
  localparam int CordicSteps = 16;
  localparam int NSteps      = (CordicSteps < 24) ? CordicSteps : 24;
  localparam int StepW       = 5;
  localparam int PosW        = 48;
  localparam int TimeW       = 40;
  localparam int RateW       = 32;
  localparam int DtW         = 20;
  localparam int SpeedW      = 15;
  localparam logic [DtW-1:0] OneSecondUs = 20'd1000000;
  localparam logic [SpeedW-1:0] SpeedReset = 15'd500;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic start;
    logic busy;
  } ctl_t;

  function automatic logic [31:0] atan_turn(input logic [StepW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage

// ===== hw/rtl/dri_cordic.sv =====
// Iterative rotation-mode CORDIC giving Q28 cosine and sine, one step per cycle.
module dri_cordic import dri_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctl_t                    ctl_i,
  input  logic [AngleBits-1:0]    angle_i,
  output logic                    done_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);
  logic signed [33:0] x_q, x_d, y_q, y_d, xs, ys, xo, yo;
  logic signed [33:0] z_q, z_d;
  logic flip_q, flip_d, run_q, run_d;
  logic [StepW-1:0] i_q, i_d;
  logic [31:0] a;

  always_comb begin
    a = {angle_i, {(32-AngleBits){1'b0}}};
    x_d = x_q; y_d = y_q; z_d = z_q; flip_d = flip_q; run_d = run_q; i_d = i_q;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    done_o = 1'b0;
    if (ctl_i.start) begin
      flip_d = (a >= 32'h40000000) && (a < 32'hC0000000);
      z_d = flip_d ? {{2{~a[31]}}, ~a[31], a[30:0]} : {{2{a[31]}}, a};
      x_d = CordicGain; y_d = '0; i_d = '0; run_d = 1'b1;
    end else if (run_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - $signed({2'b0, atan_turn(i_q)});
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + $signed({2'b0, atan_turn(i_q)});
      end
      i_d = i_q + 1'b1;
      if (i_q == StepW'(NSteps - 1)) begin
        run_d = 1'b0;
      end
    end else begin
      done_o = ctl_i.busy && (i_q == StepW'(NSteps));
    end
    xo = (flip_q ? -x_q : x_q) + 34'sd2;
    yo = (flip_q ? -y_q : y_q) + 34'sd2;
    cos_o = xo[33:2];
    sin_o = yo[33:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      i_q <= '0;
    end else begin
      run_q <= run_d;
      i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; flip_q <= flip_d;
  end
endmodule

// ===== hw/rtl/dri_divider.sv =====
// Restoring divider, one quotient bit per cycle, giving the saturated turn rate.
module dri_divider import dri_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  input  logic signed [AngleBits-1:0] delta_i,
  input  logic [DtW-1:0]           dt_i,
  output logic                     done_o,
  output logic signed [RateW-1:0]  rate_o
);
  localparam int NumW = AngleBits + 20;
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] num_q, num_d;
  logic [DtW:0] rem_q, rem_d, trial;
  logic neg_q, neg_d, run_q, run_d;
  logic [CntW-1:0] c_q, c_d;
  logic [NumW-1:0] mag;
  logic [NumW:0] sq;

  always_comb begin
    mag = NumW'(delta_i[AngleBits-1] ? -$signed({{4{delta_i[AngleBits-1]}}, delta_i})
                                      : $signed({{4{1'b0}}, delta_i})) * NumW'(OneSecondUs);
    num_d = num_q; rem_d = rem_q; neg_d = neg_q; run_d = run_q; c_d = c_q;
    trial = {rem_q[DtW-1:0], num_q[NumW-1]};
    done_o = 1'b0;
    if (ctl_i.start) begin
      num_d = mag; rem_d = '0; neg_d = delta_i[AngleBits-1]; c_d = '0; run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dt_i}) begin
        rem_d = trial - {1'b0, dt_i};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      c_d = c_q + 1'b1;
      if (c_q == CntW'(NumW - 1)) begin
        run_d = 1'b0;
      end
    end else begin
      done_o = ctl_i.busy && (c_q == CntW'(NumW));
    end
    sq = neg_q ? -{1'b0, num_q} : {1'b0, num_q};
    if (!neg_q && num_q > NumW'(32'h7FFFFFFF)) begin
      rate_o = 32'sh7FFFFFFF;
    end else if (neg_q && num_q > NumW'(33'h80000000)) begin
      rate_o = 32'sh80000000;
    end else begin
      rate_o = sq[RateW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      c_q <= '0;
    end else begin
      run_q <= run_d;
      c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; neg_q <= neg_d;
  end
endmodule

// ===== hw/rtl/dead_reckoning_integrator_top.sv =====
// Top level of the dead reckoning integrator: control, step products and state.
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / stall | heading_i, elapsed_us_i
// out     | output    | valid / stall | pos_x_o, pos_y_o, turn_rate_o, total_time_us_o, updated_o
// cfg     | input     | valid / ready | cfg_data_i
// An updating beat goes from the run state, set by the divider's 36 quotient bits with the
// 16-step CORDIC alongside, through the multiply and add states to the output state, where
// its result is shown. A skipped beat goes from idle straight to the output state.
// Reset loads speed 500 and clears position, time, last heading, turn rate and done flags.
// The input is stalled while a beat is in work or a result waits to be taken.
module dead_reckoning_integrator_top import dri_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [15:0]      heading_i,
  input  logic [DtW-1:0]          elapsed_us_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PosW-1:0]  pos_x_o,
  output logic signed [PosW-1:0]  pos_y_o,
  output logic signed [RateW-1:0] turn_rate_o,
  output logic [TimeW-1:0]        total_time_us_o,
  output logic                    updated_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic signed [SpeedW-1:0] cfg_data_i
);
  localparam logic [2:0] StIdle = 3'd0, StRun = 3'd1, StMul = 3'd2, StAdd = 3'd3,
                         StOut = 3'd4;
  logic [2:0] st_q, st_d;
  logic [SpeedW-1:0] speed_q;
  logic [PosW-1:0] px_q, py_q;
  logic [TimeW-1:0] tt_q;
  logic [AngleBits-1:0] ph_q, hd_q;
  logic [RateW-1:0] rate_q;
  logic [DtW-1:0] dt_q;
  logic upd_q, cdone_q, ddone_q;
  logic signed [35:0] p_q;
  logic signed [67:0] mx_q, my_q;
  logic signed [67:0] rx, ry;
  ctl_t ctl;
  logic cdone, ddone;
  logic signed [31:0] cs, sn;
  logic signed [RateW-1:0] rate;
  logic signed [AngleBits-1:0] delta;
  logic acc;

  assign in_stall_o = (st_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign acc = in_valid_i && !in_stall_o;
  assign ctl.start = acc && (elapsed_us_i != '0) && (elapsed_us_i < OneSecondUs);
  assign ctl.busy = (st_q == StRun);
  assign delta = hd_q - ph_q;

  dri_cordic u_cordic (.clk_i, .rst_ni, .ctl_i(ctl), .angle_i(heading_i[AngleBits-1:0]),
                       .done_o(cdone), .cos_o(cs), .sin_o(sn));
  dri_divider u_div (.clk_i, .rst_ni, .ctl_i(ctl),
                     .delta_i(ctl.start ? $signed(heading_i[AngleBits-1:0] - ph_q) : delta),
                     .dt_i(dt_q), .done_o(ddone), .rate_o(rate));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (acc) st_d = ctl.start ? StRun : StOut;
      StRun: if ((cdone_q || cdone) && (ddone_q || ddone)) st_d = StMul;
      StMul: st_d = StAdd;
      StAdd: st_d = StOut;
      StOut: if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
    rx = mx_q + 68'sd134217728;
    ry = my_q + 68'sd134217728;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; speed_q <= SpeedReset; px_q <= '0; py_q <= '0; tt_q <= '0;
      ph_q <= '0; rate_q <= '0; upd_q <= 1'b0; cdone_q <= 1'b0; ddone_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) speed_q <= cfg_data_i;
      if (ctl.start) begin
        cdone_q <= 1'b0; ddone_q <= 1'b0;
      end else begin
        if (cdone) cdone_q <= 1'b1;
        if (ddone) ddone_q <= 1'b1;
      end
      if (acc) upd_q <= ctl.start;
      if (st_q == StRun && st_d == StMul) rate_q <= rate;
      if (st_q == StAdd) begin
        px_q <= px_q + PosW'(rx >>> 28);
        py_q <= py_q + PosW'(ry >>> 28);
        tt_q <= tt_q + TimeW'(dt_q);
        ph_q <= hd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      hd_q <= heading_i[AngleBits-1:0];
      dt_q <= elapsed_us_i;
      p_q <= $signed(speed_q) * $signed({1'b0, elapsed_us_i});
    end
    mx_q <= p_q * cs;
    my_q <= p_q * sn;
  end

  assign out_valid_o = (st_q == StOut);
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign turn_rate_o = rate_q;
  assign total_time_us_o = tt_q;
  assign updated_o = upd_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !acc) else $error("beat accepted while busy");
  a_skip_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !ctl.start) |=> $stable(px_q) && $stable(tt_q)) else $error("skip moved state");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(px_q)) else $error("result lost");
`endif
endmodule
